@@ rtl/point_heading_atan2_macros.svh @@
// Assertion macros shared by the point heading checker.
`ifndef POINT_HEADING_ATAN2_MACROS_SVH
`define POINT_HEADING_ATAN2_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PHA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pha check failed: same-cycle rule");

// Next-cycle implication, checked outside reset.
`define PHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pha check failed: next-cycle rule");

// Condition that must hold in the cycle after reset is seen.
`define PHA_ASSERT_AFTER_RESET(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("pha check failed: reset rule");

`endif

@@ rtl/pha_pkg.sv @@
// Shared constants, types and the arctangent table of the point heading block.
package pha_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int ANGLE_WIDTH_DEF = 16;

  // The larger magnitude is normalized so that its top set bit sits at NORM_TOP.
  localparam int NORM_TOP = 59;
  localparam int SH_W     = 6;
  // Rotator datapath: grows by the CORDIC gain, stays below 2^62.
  localparam int DP_W     = 63;
  localparam int CORDIC_STEPS = 31;
  // Angles are in units of 2^-32 of a turn and wrap modulo one turn.
  localparam int Z_W      = 32;

  typedef logic signed [DP_W-1:0] dp_t;
  typedef logic signed [Z_W-1:0]  ang_t;

  localparam ang_t TURN_EIGHTH  = 32'sh2000_0000;
  localparam ang_t TURN_QUARTER = 32'sh4000_0000;
  localparam ang_t TURN_HALF    = 32'sh8000_0000;

  // Case flags that travel beside the rotator data.
  typedef struct packed {
    logic same;     // target straight up or equal to start
    logic ax_zero;  // no horizontal offset
    logic ay_zero;  // no vertical offset
    logic diag;     // equal offsets
    logic dx_pos;
    logic dy_pos;
    logic dy_neg;
  } pha_case_t;

  // atan(2^-i) as a fraction of a turn, scaled by 2^32 and rounded.
  localparam ang_t ATAN_TAB [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81,
    32'sd41,        32'sd20,        32'sd10,        32'sd5,
    32'sd3,         32'sd1,         32'sd1
  };

endpackage

@@ rtl/pha_prep.sv @@
// Front end: offsets, magnitudes, case flags and normalization in three stages.
module pha_prep #(
  parameter int COORD_WIDTH = pha_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] from_x,
  input  logic signed [COORD_WIDTH-1:0] from_y,
  input  logic signed [COORD_WIDTH-1:0] to_x,
  input  logic signed [COORD_WIDTH-1:0] to_y,
  output logic                          out_valid,
  output pha_pkg::dp_t                  out_x,
  output pha_pkg::dp_t                  out_y,
  output pha_pkg::pha_case_t            out_case
);

  localparam int MW    = COORD_WIDTH + 1;
  localparam int MSB_W = $clog2(MW);

  logic signed [MW-1:0] dx;
  logic signed [MW-1:0] dy;
  logic [MW-1:0]        dx_mag;
  logic [MW-1:0]        dy_mag;

  // Stage A registers.
  logic          a_valid;
  logic [MW-1:0] a_ax;
  logic [MW-1:0] a_ay;
  logic          a_dx_zero;
  logic          a_dx_pos;
  logic          a_dy_pos;
  logic          a_dy_neg;

  // Stage B logic and registers.
  logic [MW-1:0]            mag_or;
  logic [MSB_W-1:0]         msb;
  logic [pha_pkg::SH_W-1:0] sh_next;
  pha_pkg::pha_case_t       case_next;
  logic                     b_valid;
  logic [MW-1:0]            b_ax;
  logic [MW-1:0]            b_ay;
  logic [pha_pkg::SH_W-1:0] b_sh;
  pha_pkg::pha_case_t       b_case;

  logic [pha_pkg::DP_W-1:0] ax_ext;
  logic [pha_pkg::DP_W-1:0] ay_ext;

  assign dx = {to_x[COORD_WIDTH-1], to_x} - {from_x[COORD_WIDTH-1], from_x};
  assign dy = {from_y[COORD_WIDTH-1], from_y} - {to_y[COORD_WIDTH-1], to_y};
  assign dx_mag = dx[MW-1] ? -dx : dx;
  assign dy_mag = dy[MW-1] ? -dy : dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ax      <= dx_mag;
      a_ay      <= dy_mag;
      a_dx_zero <= (dx == '0);
      a_dx_pos  <= !dx[MW-1] && (dx != '0);
      a_dy_pos  <= !dy[MW-1] && (dy != '0);
      a_dy_neg  <= dy[MW-1];
    end
  end

  // The top set bit of the larger magnitude is the top set bit of the OR of both.
  assign mag_or = a_ax | a_ay;

  always_comb begin
    msb = '0;
    for (int i = 0; i < MW; i++) begin
      if (mag_or[i]) begin
        msb = MSB_W'(i);
      end
    end
  end

  assign sh_next = pha_pkg::SH_W'(pha_pkg::NORM_TOP) - pha_pkg::SH_W'(msb);

  always_comb begin
    case_next.same    = a_dx_zero && !a_dy_neg;
    case_next.ax_zero = (a_ax == '0);
    case_next.ay_zero = (a_ay == '0);
    case_next.diag    = (a_ax == a_ay);
    case_next.dx_pos  = a_dx_pos;
    case_next.dy_pos  = a_dy_pos;
    case_next.dy_neg  = a_dy_neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_ax   <= a_ax;
      b_ay   <= a_ay;
      b_sh   <= sh_next;
      b_case <= case_next;
    end
  end

  // Stage C: shift both magnitudes by the same amount.
  assign ax_ext = pha_pkg::DP_W'(b_ax);
  assign ay_ext = pha_pkg::DP_W'(b_ay);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x    <= ay_ext << b_sh;
      out_y    <= ax_ext << b_sh;
      out_case <= b_case;
    end
  end

endmodule

@@ rtl/pha_cordic.sv @@
// Vectoring CORDIC, one registered micro-rotation per stage.
module pha_cordic (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  pha_pkg::dp_t        in_x,
  input  pha_pkg::dp_t        in_y,
  input  pha_pkg::pha_case_t  in_case,
  output logic                out_valid,
  output pha_pkg::ang_t       out_z,
  output pha_pkg::pha_case_t  out_case
);

  localparam int N = pha_pkg::CORDIC_STEPS;

  logic               v_r [N];
  pha_pkg::dp_t       x_r [N];
  pha_pkg::dp_t       y_r [N];
  pha_pkg::ang_t      z_r [N];
  pha_pkg::pha_case_t c_r [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    logic               vi;
    pha_pkg::dp_t       xi;
    pha_pkg::dp_t       yi;
    pha_pkg::ang_t      zi;
    pha_pkg::pha_case_t ci;
    pha_pkg::dp_t       xs;
    pha_pkg::dp_t       ys;

    if (i == 0) begin : g_first
      assign vi = in_valid;
      assign xi = in_x;
      assign yi = in_y;
      assign zi = '0;
      assign ci = in_case;
    end else begin : g_rest
      assign vi = v_r[i-1];
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign ci = c_r[i-1];
    end

    // Arithmetic shifts floor toward minus infinity.
    assign xs = xi >>> i;
    assign ys = yi >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!yi[pha_pkg::DP_W-1]) begin
          x_r[i] <= xi + ys;
          y_r[i] <= yi - xs;
          z_r[i] <= zi + pha_pkg::ATAN_TAB[i];
        end else begin
          x_r[i] <= xi - ys;
          y_r[i] <= yi + xs;
          z_r[i] <= zi - pha_pkg::ATAN_TAB[i];
        end
        c_r[i] <= ci;
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_z     = z_r[N-1];
  assign out_case  = c_r[N-1];

endmodule

@@ rtl/pha_place.sv @@
// Back end: special-case angles, quadrant placement, rounding and output register.
module pha_place #(
  parameter int ANGLE_WIDTH = pha_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  pha_pkg::ang_t          in_z,
  input  pha_pkg::pha_case_t     in_case,
  output logic                   res_valid,
  output logic [ANGLE_WIDTH-1:0] heading,
  output logic                   up_or_same
);

  // Half of one output step, in 2^-32 turn units; zero at full width.
  localparam logic [pha_pkg::Z_W-1:0] RND =
    (pha_pkg::Z_W'(1) << (pha_pkg::Z_W - ANGLE_WIDTH)) >> 1;

  pha_pkg::ang_t phi;
  pha_pkg::ang_t h_next;

  logic                     p_valid;
  logic [pha_pkg::Z_W-1:0]  p_h;
  logic                     p_same;
  logic [pha_pkg::Z_W-1:0]  h_rnd;

  always_comb begin
    if (in_case.ax_zero) begin
      phi = '0;
    end else if (in_case.ay_zero) begin
      phi = pha_pkg::TURN_QUARTER;
    end else if (in_case.diag) begin
      phi = pha_pkg::TURN_EIGHTH;
    end else begin
      phi = in_z;
    end

    // All sums wrap modulo one turn.
    if (in_case.dx_pos) begin
      h_next = in_case.dy_pos ? phi : pha_pkg::TURN_HALF - phi;
    end else if (in_case.dy_neg) begin
      h_next = pha_pkg::TURN_HALF + phi;
    end else begin
      h_next = -phi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_h    <= h_next;
      p_same <= in_case.same;
    end
  end

  assign h_rnd = p_h + RND;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      heading    <= p_same ? '0 : h_rnd[pha_pkg::Z_W-1 -: ANGLE_WIDTH];
      up_or_same <= p_same;
    end
  end

endmodule

@@ rtl/point_heading_atan2.sv @@
// Top level of the point heading block: heading from one image point to another.
//
// Input channel (pts_valid / pts_stall): one transfer carries a start point
// (from_x, from_y) and a target point (to_x, to_y). Output channel
// (res_valid / res_stall): one transfer per input item carries heading, the
// clockwise angle from image-up in 1/2^ANGLE_WIDTH turn units, and up_or_same,
// which is set (with heading 0) when the target is straight up or equal.
// The datapath is a 36-stage pipeline: three front-end stages take offsets and
// normalize the magnitudes, 31 CORDIC micro-rotation stages find the angle, and
// two back-end stages place it in its quadrant and round it into the output
// register. One item can be accepted every cycle, so the throughput is one item
// per clock while the receiver does not stall the output register.
// All stages advance together on one enable. When the output register holds a
// result that the receiver stalls, the whole pipeline freezes and pts_stall is
// raised in the same cycle; nothing is dropped or repeated, and bubbles ahead
// of the output still advance as soon as the stall lifts.
// Synchronous reset clears every stage's valid bit; the block keeps no other
// state between items.
module point_heading_atan2 #(
  parameter int COORD_WIDTH = pha_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = pha_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pts_valid,
  output logic                          pts_stall,
  input  logic signed [COORD_WIDTH-1:0] from_x,
  input  logic signed [COORD_WIDTH-1:0] from_y,
  input  logic signed [COORD_WIDTH-1:0] to_x,
  input  logic signed [COORD_WIDTH-1:0] to_y,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [ANGLE_WIDTH-1:0]        heading,
  output logic                          up_or_same
);

  // Pipeline enable: move whenever the output register is empty or drained.
  logic en;

  logic               prep_valid;
  pha_pkg::dp_t       prep_x;
  pha_pkg::dp_t       prep_y;
  pha_pkg::pha_case_t prep_case;

  logic               rot_valid;
  pha_pkg::ang_t      rot_z;
  pha_pkg::pha_case_t rot_case;

  assign en        = !res_valid || !res_stall;
  assign pts_stall = !en;

  // Offsets, magnitudes and the common normalizing shift.
  pha_prep #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pts_valid),
    .from_x    (from_x),
    .from_y    (from_y),
    .to_x      (to_x),
    .to_y      (to_y),
    .out_valid (prep_valid),
    .out_x     (prep_x),
    .out_y     (prep_y),
    .out_case  (prep_case)
  );

  // First-quadrant angle, measured from the vertical axis.
  pha_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (prep_valid),
    .in_x      (prep_x),
    .in_y      (prep_y),
    .in_case   (prep_case),
    .out_valid (rot_valid),
    .out_z     (rot_z),
    .out_case  (rot_case)
  );

  // Exact angles for axis and diagonal offsets, quadrant, rounding.
  pha_place #(
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_place (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (rot_valid),
    .in_z       (rot_z),
    .in_case    (rot_case),
    .res_valid  (res_valid),
    .heading    (heading),
    .up_or_same (up_or_same)
  );

endmodule

@@ rtl/pha_checker.sv @@
// Port-level checks of the point heading block and their binding to the top level.
`include "point_heading_atan2_macros.svh"

module pha_checker #(
  parameter int ANGLE_WIDTH = pha_pkg::ANGLE_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   pts_stall,
  input logic                   res_valid,
  input logic                   res_stall,
  input logic [ANGLE_WIDTH-1:0] heading,
  input logic                   up_or_same
);

  // A stalled result stays in place with the same payload.
  `PHA_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(heading) && $stable(up_or_same))

  // Straight-up and same-point results always carry heading zero.
  `PHA_ASSERT_NOW(a_up_zero, clk, rst, res_valid && up_or_same, heading == '0)

  // The input side is held back only by a stalled result waiting at the output.
  `PHA_ASSERT_NOW(a_stall_cause, clk, rst, pts_stall, res_valid && res_stall)

  // Reset leaves no result pending.
  `PHA_ASSERT_AFTER_RESET(a_reset_empty, clk, rst, !res_valid)

endmodule

bind point_heading_atan2 pha_checker #(
  .ANGLE_WIDTH (ANGLE_WIDTH)
) u_pha_checker (
  .clk        (clk),
  .rst        (rst),
  .pts_stall  (pts_stall),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .heading    (heading),
  .up_or_same (up_or_same)
);

@@ tb/sv/point_heading_checker.sv @@
`timescale 1ns / 100ps
// Checker that predicts each heading from the accepted point pairs and compares the results.
module point_heading_checker #(
  parameter int COORD_WIDTH = pha_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = pha_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pts_valid,
  input  logic                          pts_stall,
  input  logic signed [COORD_WIDTH-1:0] from_x,
  input  logic signed [COORD_WIDTH-1:0] from_y,
  input  logic signed [COORD_WIDTH-1:0] to_x,
  input  logic signed [COORD_WIDTH-1:0] to_y,
  input  logic                          res_valid,
  input  logic                          res_stall,
  input  logic [ANGLE_WIDTH-1:0]        heading,
  input  logic                          up_or_same,
  output int                            mismatches,
  output int                            outstanding
);

  typedef struct packed {
    logic [ANGLE_WIDTH-1:0] heading;
    logic                   up_or_same;
  } heading_res_t;

  // Angles inside the predictor are in units of 2^-32 turn.
  localparam longint          FULL_TURN  = 64'sh1_0000_0000;
  localparam longint unsigned NORM_FLOOR = 64'd1 << pha_pkg::NORM_TOP;
  localparam int              MAX_REPORTS = 10;

  heading_res_t expected_headings[$];
  int           mismatch_count = 0;

  assign mismatches = mismatch_count;

  // Vectoring rotation on the first-quadrant magnitudes; returns the angle from the
  // vertical axis toward the horizontal one.
  function automatic longint quadrant_angle(longint unsigned ax, longint unsigned ay);
    longint unsigned big;
    longint          xr, yr, zr, xs, ys;
    big = (ax > ay) ? ax : ay;
    while (big < NORM_FLOOR) begin
      big = big << 1;
      ax  = ax << 1;
      ay  = ay << 1;
    end
    xr = ay;
    yr = ax;
    zr = 0;
    for (int i = 0; i < pha_pkg::CORDIC_STEPS; i++) begin
      xs = xr >>> i;
      ys = yr >>> i;
      if (yr >= 0) begin
        xr = xr + ys;
        yr = yr - xs;
        zr = zr + longint'(pha_pkg::ATAN_TAB[i]);
      end else begin
        xr = xr - ys;
        yr = yr + xs;
        zr = zr - longint'(pha_pkg::ATAN_TAB[i]);
      end
    end
    return zr;
  endfunction

  function automatic heading_res_t predict_heading(logic signed [COORD_WIDTH-1:0] fx,
                                                   logic signed [COORD_WIDTH-1:0] fy,
                                                   logic signed [COORD_WIDTH-1:0] tx,
                                                   logic signed [COORD_WIDTH-1:0] ty);
    longint          dx, dy, phi, turn_pos;
    longint unsigned ax, ay, rounded;
    heading_res_t    res;
    dx = longint'(tx) - longint'(fx);
    dy = longint'(fy) - longint'(ty);
    res.heading    = '0;
    res.up_or_same = 1'b1;
    if (dx == 0 && dy >= 0) begin
      return res;
    end
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax == 0) begin
      phi = 0;
    end else if (ay == 0) begin
      phi = FULL_TURN / 4;
    end else if (ax == ay) begin
      phi = FULL_TURN / 8;
    end else begin
      phi = quadrant_angle(ax, ay);
    end
    if (dx > 0) begin
      turn_pos = (dy > 0) ? phi : FULL_TURN / 2 - phi;
    end else if (dy < 0) begin
      turn_pos = FULL_TURN / 2 + phi;
    end else begin
      turn_pos = FULL_TURN - phi;
    end
    rounded = turn_pos;
    if (ANGLE_WIDTH < 32) begin
      rounded = (rounded + (64'd1 << (31 - ANGLE_WIDTH))) >> (32 - ANGLE_WIDTH);
    end
    res.heading    = rounded[ANGLE_WIDTH-1:0];
    res.up_or_same = 1'b0;
    return res;
  endfunction

  function automatic void note_mismatch(string what, heading_res_t want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected heading=%0d up_or_same=%0b, got heading=%0d up_or_same=%0b",
               $realtime, what, want.heading, want.up_or_same, heading, up_or_same);
    end
  endfunction

  // Results leave first, so a pair accepted in the same cycle never matches itself.
  always @(posedge clk) begin : check_results
    heading_res_t want;
    if (rst) begin
      outstanding <= 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_headings.size() == 0) begin
          want = '0;
          note_mismatch("unexpected result", want);
        end else begin
          want = expected_headings.pop_front();
          if (want.heading !== heading || want.up_or_same !== up_or_same) begin
            note_mismatch("wrong result", want);
          end
        end
      end
      if (pts_valid && !pts_stall) begin
        expected_headings.push_back(predict_heading(from_x, from_y, to_x, to_y));
      end
      outstanding <= expected_headings.size();
    end
  end

endmodule

@@ tb/sv/point_heading_atan2_tb.sv @@
`timescale 1ns / 100ps
// Testbench top that drives point pairs into point_heading_atan2 and gives the verdict.
module point_heading_atan2_tb;

  localparam int COORD_WIDTH = pha_pkg::COORD_WIDTH_DEF;
  localparam int ANGLE_WIDTH = pha_pkg::ANGLE_WIDTH_DEF;

  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

  localparam int RANDOM_PAIRS = 1100;
  // The pipeline is 36 stages deep; the drain waits a little longer than that.
  localparam int DRAIN_CYCLES = 48;
  // Longest correct quiet stretch is a sender gap or a stall run plus the pipeline
  // latency, so this limit leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  typedef enum int {
    PAIR_ANY,
    PAIR_CLOSE,
    PAIR_AXIS,
    PAIR_DIAGONAL,
    PAIR_EXTREME
  } pair_kind_e;

  logic                          clk;
  logic                          rst       = 1'b1;
  logic                          pts_valid = 1'b0;
  logic                          pts_stall;
  logic signed [COORD_WIDTH-1:0] from_x    = '0;
  logic signed [COORD_WIDTH-1:0] from_y    = '0;
  logic signed [COORD_WIDTH-1:0] to_x      = '0;
  logic signed [COORD_WIDTH-1:0] to_y      = '0;
  logic                          res_valid;
  logic                          res_stall = 1'b0;
  logic [ANGLE_WIDTH-1:0]        heading;
  logic                          up_or_same;

  int          mismatches;
  int          outstanding;
  int          burst_left   = 0;
  int          stall_phase  = 0;
  stall_mode_e stall_mode   = STALL_NONE;
  int          quiet_cycles = 0;

  point_heading_atan2 #(
    .COORD_WIDTH(COORD_WIDTH),
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .pts_valid (pts_valid),
    .pts_stall (pts_stall),
    .from_x    (from_x),
    .from_y    (from_y),
    .to_x      (to_x),
    .to_y      (to_y),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .heading   (heading),
    .up_or_same(up_or_same)
  );

  // The checker sees the same wires as the block and keeps the expected headings.
  point_heading_checker #(
    .COORD_WIDTH(COORD_WIDTH),
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_check (
    .clk        (clk),
    .rst        (rst),
    .pts_valid  (pts_valid),
    .pts_stall  (pts_stall),
    .from_x     (from_x),
    .from_y     (from_y),
    .to_x       (to_x),
    .to_y       (to_y),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .heading    (heading),
    .up_or_same (up_or_same),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The receiver keeps each stall behavior for a random stretch, then draws a new one: no stalls
  // at all, sparse random stalls, dense random stalls, and a fixed periodic pattern.
  // This puts stalls on every stage of the pipeline's fill and drain.
  always @(posedge clk) begin
    if (rst) begin
      res_stall   <= 1'b0;
      stall_phase <= 0;
      stall_mode  <= STALL_NONE;
    end else begin
      if (stall_phase == 0) begin
        stall_mode  <= stall_mode_e'($urandom_range(0, 3));
        stall_phase <= $urandom_range(20, 120);
      end else begin
        stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
        STALL_NONE: begin
          res_stall <= 1'b0;
        end
        STALL_LIGHT: begin
          res_stall <= ($urandom_range(0, 4) == 0);
        end
        STALL_HEAVY: begin
          res_stall <= ($urandom_range(0, 2) != 0);
        end
        default: begin
          res_stall <= (stall_phase % 16 < 6);
        end
      endcase
    end
  end

  // The watchdog counts cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if ((pts_valid && !pts_stall) || (res_valid && !res_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Presents one point pair and holds it until the block takes the transfer. At the
  // end of a burst the sender drops valid for a random gap; a new burst length is
  // then drawn, now and then long enough to give a stretch with no sender idling.
  task automatic send_pair(logic signed [COORD_WIDTH-1:0] fx, logic signed [COORD_WIDTH-1:0] fy,
                           logic signed [COORD_WIDTH-1:0] tx, logic signed [COORD_WIDTH-1:0] ty);
    int gap;
    from_x    <= fx;
    from_y    <= fy;
    to_x      <= tx;
    to_y      <= ty;
    pts_valid <= 1'b1;
    @(posedge clk);
    while (pts_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left = burst_left - 1;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 160) : $urandom_range(0, 12);
      gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
      pts_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [COORD_WIDTH-1:0] edge_coord();
    case ($urandom_range(0, 5))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return '0;
      3:       return '1;
      4:       return COORD_WIDTH'(1);
      default: return COORD_WIDTH'($urandom);
    endcase
  endfunction

  // Directed pairs: equal points, each axis direction, each diagonal, the widest
  // spans, headings that round up to a full turn, and ordinary quadrant points.
  task automatic send_directed();
    send_pair(0, 0, 0, 0);
    send_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    send_pair(-1, -1, -1, -1);
    send_pair(100, 50, 100, -20);
    send_pair(100, -20, 100, 50);
    send_pair(0, 0, 7, 0);
    send_pair(0, 0, -7, 0);
    send_pair(0, 0, 5, -5);
    send_pair(0, 0, 5, 5);
    send_pair(0, 0, -5, 5);
    send_pair(0, 0, -5, -5);
    send_pair(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
    send_pair(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    send_pair(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
    // Just left of straight up: the heading rounds to a full turn and wraps to zero.
    send_pair(0, COORD_MAX, -1, COORD_MIN);
    send_pair(0, COORD_MAX, 1, COORD_MIN);
    send_pair(0, COORD_MIN, 1, COORD_MAX);
    send_pair(0, COORD_MIN, -1, COORD_MAX);
    send_pair(COORD_MIN, 0, COORD_MAX, 1);
    send_pair(COORD_MAX, 0, COORD_MIN, -1);
    send_pair(3, 4, 10, -20);
    send_pair(-1234, 5678, 4321, -8765);
    send_pair(1, 1, 2, 3);
  endtask

  // Random pairs: about half fully random, the rest aimed at the special cases
  // (near-equal points, axis-aligned offsets, diagonals, and extreme coordinates).
  task automatic send_random(int count);
    logic signed [COORD_WIDTH-1:0] fx, fy, tx, ty, span;
    pair_kind_e                    kind;
    for (int n = 0; n < count; n++) begin
      fx   = COORD_WIDTH'($urandom);
      fy   = COORD_WIDTH'($urandom);
      tx   = COORD_WIDTH'($urandom);
      ty   = COORD_WIDTH'($urandom);
      span = COORD_WIDTH'($urandom);
      kind = ($urandom_range(0, 9) < 5) ? PAIR_ANY : pair_kind_e'($urandom_range(1, 4));
      case (kind)
        PAIR_CLOSE: begin
          tx = COORD_WIDTH'(fx + $signed($urandom_range(0, 6)) - 3);
          ty = COORD_WIDTH'(fy + $signed($urandom_range(0, 6)) - 3);
        end
        PAIR_AXIS: begin
          if ($urandom_range(0, 1) == 0) begin
            tx = fx;
          end else begin
            ty = fy;
          end
        end
        PAIR_DIAGONAL: begin
          tx = fx + span;
          ty = ($urandom_range(0, 1) == 0) ? fy + span : fy - span;
        end
        PAIR_EXTREME: begin
          fx = edge_coord();
          fy = edge_coord();
          tx = edge_coord();
          ty = edge_coord();
        end
        default: begin
        end
      endcase
      send_pair(fx, fy, tx, ty);
    end
  endtask

  // Reset is held first, then directed and random pairs are sent. After
  // the last transfer the run waits for every expected heading and a drain time.
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_directed();
    send_random(RANDOM_PAIRS);
    if (pts_valid) begin
      pts_valid <= 1'b0;
    end
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ point_heading_atan2.f @@
+incdir+rtl
rtl/pha_pkg.sv
rtl/pha_prep.sv
rtl/pha_cordic.sv
rtl/pha_place.sv
rtl/point_heading_atan2.sv
rtl/pha_checker.sv
tb/sv/point_heading_checker.sv
tb/sv/point_heading_atan2_tb.sv
